@@ sv/bra_pkg.sv @@
// shared types and constants of the bitmap register allocator
`default_nettype none

package bra_pkg;

    // one memory row carries this many slots (allocated and pinned half each)
    localparam int WORD_W = 16;
    localparam int BIT_W  = 4;
    localparam int CNT_W  = 9;
    localparam int SLOT_W = 8;
    localparam int KIND_W = 3;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC_ONE   = 3'd0,
        K_ALLOC_RANGE = 3'd1,
        K_FREE_RANGE  = 3'd2,
        K_PIN         = 3'd3,
        K_UNPIN       = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_RESULT
    } t_state;

    // what one row tells the search
    typedef struct packed {
        logic              free_hit;
        logic [BIT_W-1:0]  free_pos;
        logic              run_hit;
        logic [BIT_W-1:0]  run_pos;
        logic [CNT_W-1:0]  tail_run;
    } t_scan_res;

endpackage

`default_nettype wire

@@ sv/bitmap_register_allocator.sv @@
// top level: request sequencer over the slot bitmap memory
//
//  channel   direction  handshake                    payload
//  request   in         i_req_valid / o_req_ready    i_kind i_slot i_count i_keep
//  result    out        o_rsp_valid / i_rsp_ready    o_first_slot o_ok
//
// state sits in one memory of ROWS rows, 16 slots per row, allocated and pinned halves
// allocate one / range: one row read per cycle until a fit, then read-modify-write of the
//   rows that change, one row per cycle
// free range, pin, unpin: read-modify-write of the rows touched; some cases are decided at entry
// reset clears the state through per-row valid bits at once, no clearing pass
// one request at a time; a finished result waits in the output register and a new
//   request is taken meanwhile, the next result holds until that register is free
`default_nettype none

module bitmap_register_allocator #(
    parameter int NUM_SLOTS = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    output logic                             o_req_ready,
    input  wire logic [bra_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [bra_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [bra_pkg::CNT_W-1:0]   i_count,
    input  wire logic                        i_keep,
    output logic                             o_rsp_valid,
    input  wire logic                        i_rsp_ready,
    output logic      [bra_pkg::SLOT_W-1:0]  o_first_slot,
    output logic                             o_ok
);

    localparam int W     = bra_pkg::WORD_W;
    localparam int WB    = bra_pkg::BIT_W;
    localparam int ROWS  = (NUM_SLOTS + W - 1) / W;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = ROW_W + WB;
    // wide enough for the slot total and for slot + count
    localparam int EXT_W = (IDX_W + 1 > 10) ? IDX_W + 1 : 10;
    localparam logic [EXT_W-1:0] NUM_EXT  = EXT_W'(NUM_SLOTS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // control
    bra_pkg::t_state r_state, n_state;
    logic            r_pend, n_pend;
    logic            r_issue_more, n_issue_more;
    logic            r_out_valid, n_out_valid;

    // request payload and walk bookkeeping
    bra_pkg::t_kind              r_kind, n_kind;
    logic [bra_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        r_keep, n_keep;
    logic [IDX_W-1:0]            r_lo, n_lo;
    logic [IDX_W-1:0]            r_hi, n_hi;
    logic [ROW_W-1:0]            r_issue_row, n_issue_row;
    logic [ROW_W-1:0]            r_drow, n_drow;
    logic [bra_pkg::CNT_W-1:0]   r_carry, n_carry;
    logic [bra_pkg::SLOT_W-1:0]  r_res_first, n_res_first;
    logic                        r_res_ok, n_res_ok;
    logic [bra_pkg::SLOT_W-1:0]  r_out_first, n_out_first;
    logic                        r_out_ok, n_out_ok;

    // memory port
    logic                        rd_en;
    logic [ROW_W-1:0]            rd_row;
    logic                        wr_en;
    logic [ROW_W-1:0]            wr_row;
    logic [2*W-1:0]              wr_data;
    logic [2*W-1:0]              rd_data;

    bra_pkg::t_word              legal;
    bra_pkg::t_scan_res          scan;

    bra_store #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_row  (rd_row),
        .i_wr_en   (wr_en),
        .i_wr_row  (wr_row),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // slots at index NUM_SLOTS and beyond count as taken
    always_comb begin
        for (int k = 0; k < W; k++) begin
            legal[k] = (EXT_W'({r_drow, WB'(k)}) < NUM_EXT);
        end
    end

    bra_scan u_scan (
        .i_alloc (rd_data[W-1:0]),
        .i_legal (legal),
        .i_carry (r_carry),
        .i_count (r_count),
        .o_res   (scan)
    );

    assign o_req_ready  = (r_state == bra_pkg::S_IDLE);
    assign o_rsp_valid  = r_out_valid;
    assign o_first_slot = r_out_first;
    assign o_ok         = r_out_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bra_pkg::S_IDLE;
            r_pend       <= 1'b0;
            r_issue_more <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_issue_more <= n_issue_more;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_count     <= n_count;
        r_keep      <= n_keep;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_issue_row <= n_issue_row;
        r_drow      <= n_drow;
        r_carry     <= n_carry;
        r_res_first <= n_res_first;
        r_res_ok    <= n_res_ok;
        r_out_first <= n_out_first;
        r_out_ok    <= n_out_ok;
    end

    always_comb begin
        logic [EXT_W-1:0]  sum;
        logic [EXT_W-1:0]  start_ext;
        logic [IDX_W-1:0]  end_idx;
        logic [WB-1:0]     lo_b;
        logic [WB-1:0]     hi_b;
        bra_pkg::t_word    mask;
        bra_pkg::t_word    alloc_w;
        bra_pkg::t_word    pin_w;

        n_state      = r_state;
        n_pend       = 1'b0;
        n_issue_more = r_issue_more;
        n_out_valid  = r_out_valid && !i_rsp_ready;
        n_kind       = r_kind;
        n_count      = r_count;
        n_keep       = r_keep;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_issue_row  = r_issue_row;
        n_drow       = r_issue_row;
        n_carry      = r_carry;
        n_res_first  = r_res_first;
        n_res_ok     = r_res_ok;
        n_out_first  = r_out_first;
        n_out_ok     = r_out_ok;

        rd_en   = 1'b0;
        rd_row  = r_issue_row;
        wr_en   = 1'b0;
        wr_row  = r_drow;
        wr_data = rd_data;

        sum       = '0;
        start_ext = '0;
        end_idx   = '0;

        // row mask for the walk over [r_lo, r_hi]
        lo_b = (r_drow == r_lo[IDX_W-1:WB]) ? r_lo[WB-1:0] : '0;
        hi_b = (r_drow == r_hi[IDX_W-1:WB]) ? r_hi[WB-1:0] : '1;
        for (int k = 0; k < W; k++) begin
            mask[k] = (WB'(k) >= lo_b) && (WB'(k) <= hi_b);
        end
        alloc_w = rd_data[W-1:0];
        pin_w   = rd_data[2*W-1:W];
        unique case (r_kind)
            bra_pkg::K_ALLOC_ONE,
            bra_pkg::K_ALLOC_RANGE: alloc_w = alloc_w | mask;
            bra_pkg::K_FREE_RANGE:  alloc_w = alloc_w & ~(mask & ~pin_w);
            bra_pkg::K_PIN:         pin_w   = pin_w | mask;
            bra_pkg::K_UNPIN: begin
                pin_w = pin_w & ~mask;
                if (!r_keep) begin
                    alloc_w = alloc_w & ~mask;
                end
            end
            default: ;
        endcase

        unique case (r_state)
            bra_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_kind       = bra_pkg::t_kind'(i_kind);
                    n_count      = i_count;
                    n_keep       = i_keep;
                    n_res_first  = '0;
                    n_res_ok     = 1'b0;
                    n_issue_row  = '0;
                    n_issue_more = 1'b1;
                    n_carry      = '0;
                    n_lo         = IDX_W'(i_slot);
                    n_hi         = IDX_W'(i_slot);
                    n_state      = bra_pkg::S_RESULT;
                    unique case (bra_pkg::t_kind'(i_kind))
                        bra_pkg::K_ALLOC_ONE: begin
                            n_state = bra_pkg::S_SCAN;
                        end
                        bra_pkg::K_ALLOC_RANGE: begin
                            // zero count succeeds at once, oversize fails at once
                            if (i_count == '0) begin
                                n_res_ok = 1'b1;
                            end else if (EXT_W'(i_count) <= NUM_EXT) begin
                                n_state = bra_pkg::S_SCAN;
                            end
                        end
                        bra_pkg::K_FREE_RANGE: begin
                            n_res_ok = 1'b1;
                            sum      = EXT_W'(i_slot) + EXT_W'(i_count) - EXT_W'(1);
                            if (i_count != '0 && EXT_W'(i_slot) < NUM_EXT) begin
                                // no wrap: clip at the last slot
                                n_hi = (sum >= NUM_EXT) ? IDX_W'(NUM_EXT - EXT_W'(1))
                                                        : IDX_W'(sum);
                                n_issue_row = n_lo[IDX_W-1:WB];
                                n_state     = bra_pkg::S_WALK;
                            end
                        end
                        bra_pkg::K_PIN,
                        bra_pkg::K_UNPIN: begin
                            if (EXT_W'(i_slot) < NUM_EXT) begin
                                n_res_ok    = 1'b1;
                                n_issue_row = n_lo[IDX_W-1:WB];
                                n_state     = bra_pkg::S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            bra_pkg::S_SCAN: begin
                // stream row reads, evaluate the row issued last cycle
                rd_en = r_issue_more;
                if (r_issue_more) begin
                    n_issue_row  = r_issue_row + ROW_W'(1);
                    n_issue_more = (r_issue_row != LAST_ROW);
                end
                n_pend = rd_en;
                n_drow = r_issue_row;
                if (r_pend) begin
                    n_carry = scan.tail_run;
                    if (r_kind == bra_pkg::K_ALLOC_ONE && scan.free_hit) begin
                        n_lo         = {r_drow, scan.free_pos};
                        n_hi         = {r_drow, scan.free_pos};
                        n_res_first  = bra_pkg::SLOT_W'({r_drow, scan.free_pos});
                        n_res_ok     = 1'b1;
                        n_issue_row  = r_drow;
                        n_issue_more = 1'b1;
                        n_pend       = 1'b0;
                        n_state      = bra_pkg::S_WALK;
                    end else if (r_kind == bra_pkg::K_ALLOC_RANGE && scan.run_hit) begin
                        end_idx      = {r_drow, scan.run_pos};
                        start_ext    = EXT_W'(end_idx) + EXT_W'(1) - EXT_W'(r_count);
                        n_lo         = IDX_W'(start_ext);
                        n_hi         = end_idx;
                        n_res_first  = bra_pkg::SLOT_W'(start_ext);
                        n_res_ok     = 1'b1;
                        n_issue_row  = n_lo[IDX_W-1:WB];
                        n_issue_more = 1'b1;
                        n_pend       = 1'b0;
                        n_state      = bra_pkg::S_WALK;
                    end else if (r_drow == LAST_ROW) begin
                        // no fit anywhere
                        n_pend  = 1'b0;
                        n_state = bra_pkg::S_RESULT;
                    end
                end
            end

            bra_pkg::S_WALK: begin
                // read row r+1 while writing back row r
                rd_en = r_issue_more;
                if (r_issue_more) begin
                    n_issue_row  = r_issue_row + ROW_W'(1);
                    n_issue_more = (r_issue_row != r_hi[IDX_W-1:WB]);
                end
                n_pend = rd_en;
                n_drow = r_issue_row;
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_row  = r_drow;
                    wr_data = {pin_w, alloc_w};
                    if (r_drow == r_hi[IDX_W-1:WB]) begin
                        n_pend  = 1'b0;
                        n_state = bra_pkg::S_RESULT;
                    end
                end
            end

            bra_pkg::S_RESULT: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out_valid = 1'b1;
                    n_out_first = r_res_first;
                    n_out_ok    = r_res_ok;
                    n_state     = bra_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/bra_store.sv @@
// row memory holding allocated and pinned bits, with per-row valid bits
`default_nettype none

module bra_store #(
    parameter int ROWS  = 16,
    parameter int ROW_W = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [ROW_W-1:0]            i_rd_row,
    input  wire logic                        i_wr_en,
    input  wire logic [ROW_W-1:0]            i_wr_row,
    input  wire logic [2*bra_pkg::WORD_W-1:0] i_wr_data,
    output logic      [2*bra_pkg::WORD_W-1:0] o_rd_data
);

    logic [2*bra_pkg::WORD_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]              r_valid;
    logic [2*bra_pkg::WORD_W-1:0] r_rd_data;
    logic                         r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    // a row never written reads as all clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_row];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

@@ sv/bra_scan.sv @@
// per-row search: lowest free slot and first point where a free run reaches count
`default_nettype none

module bra_scan (
    input  wire logic [bra_pkg::WORD_W-1:0] i_alloc,
    input  wire logic [bra_pkg::WORD_W-1:0] i_legal,
    input  wire logic [bra_pkg::CNT_W-1:0]  i_carry,
    input  wire logic [bra_pkg::CNT_W-1:0]  i_count,
    output bra_pkg::t_scan_res               o_res
);

    always_comb begin
        logic [bra_pkg::WORD_W-1:0] free;
        logic [bra_pkg::WORD_W-1:0] hitv;
        logic [bra_pkg::CNT_W-1:0]  run;
        logic [bra_pkg::BIT_W-1:0]  z;
        logic                       seen;

        free  = ~i_alloc & i_legal;
        hitv  = '0;
        run   = '0;
        o_res = '0;

        for (int k = bra_pkg::WORD_W - 1; k >= 0; k--) begin
            if (free[k]) begin
                o_res.free_hit = 1'b1;
                o_res.free_pos = bra_pkg::BIT_W'(k);
            end
        end

        // run ending at each bit: from the last taken bit, or carried in from earlier rows
        for (int k = 0; k < bra_pkg::WORD_W; k++) begin
            seen = 1'b0;
            z    = '0;
            for (int j = 0; j <= k; j++) begin
                if (!free[j]) begin
                    seen = 1'b1;
                    z    = bra_pkg::BIT_W'(j);
                end
            end
            run = seen ? (bra_pkg::CNT_W'(k) - bra_pkg::CNT_W'(z))
                       : (i_carry + bra_pkg::CNT_W'(k + 1));
            hitv[k] = (run == i_count);
            if (k == bra_pkg::WORD_W - 1) begin
                o_res.tail_run = run;
            end
        end

        for (int k = bra_pkg::WORD_W - 1; k >= 0; k--) begin
            if (hitv[k]) begin
                o_res.run_hit = 1'b1;
                o_res.run_pos = bra_pkg::BIT_W'(k);
            end
        end
    end

endmodule

`default_nettype wire
